// ===== sv/assert_macros.svh =====
// Assertion macros for the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CHK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cms_pkg.sv =====
`default_nettype none

package cms_pkg;

  localparam int unsigned SITE_WINDOW = 65536;
  localparam int unsigned SITE_AW     = $clog2(SITE_WINDOW);
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned CNT_N       = 6;
  localparam int unsigned FIELD_W     = 16;

  localparam logic [7:0] ASCII_C_UP = 8'h43;
  localparam logic [7:0] ASCII_C_LO = 8'h63;
  localparam logic [7:0] ASCII_G_UP = 8'h47;
  localparam logic [7:0] ASCII_G_LO = 8'h67;
  localparam logic [7:0] ASCII_T_UP = 8'h54;
  localparam logic [7:0] ASCII_A_UP = 8'h41;
  localparam logic [7:0] MIN_QUALITY_RESET = 8'd33;

  typedef enum logic {
    ACT_OBSERVE = 1'b0,
    ACT_READ    = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    SEL_WC   = 3'd0,
    SEL_WT   = 3'd1,
    SEL_WZ   = 3'd2,
    SEL_CC   = 3'd3,
    SEL_CT   = 3'd4,
    SEL_CZ   = 3'd5,
    SEL_NONE = 3'd6
  } cnt_sel_e;

  typedef enum logic [1:0] {
    ST_CLEAR  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_UPDATE = 2'd2
  } state_e;

  typedef struct packed {
    logic        action;
    logic [15:0] site_address;
    logic [7:0]  ref_base;
    logic [7:0]  ref_next_base;
    logic [7:0]  read_base;
    logic [7:0]  read_next_base;
    logic        has_next;
    logic [7:0]  quality;
    logic        strand;
  } in_item_t;

  typedef struct packed {
    logic        is_cpg;
    logic        counted;
    logic        site_seen;
    logic [15:0] watson_c;
    logic [15:0] watson_t;
    logic [15:0] watson_other;
    logic [15:0] crick_c;
    logic [15:0] crick_t;
    logic [15:0] crick_other;
  } out_item_t;

  typedef logic [CNT_N-1:0][COUNT_WIDTH-1:0] cnt_vec_t;

  typedef struct packed {
    logic     seen;
    cnt_vec_t cnt;
  } site_entry_t;

  typedef struct packed {
    logic clr_en;
    logic load;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// ===== sv/cms_ctrl.sv =====
`default_nettype none

module cms_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  cms_pkg::ctrl_sts_t sts_i,
  output cms_pkg::ctrl_cmd_t cmd_o
);
  import cms_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_busy;

  assign out_busy = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_busy;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // hold until the output register is free
        if (!out_busy) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== sv/cms_datapath.sv =====
`default_nettype none

module cms_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cms_pkg::in_item_t  in_item_i,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  cms_pkg::ctrl_cmd_t cmd_i,
  output cms_pkg::ctrl_sts_t sts_o,
  output cms_pkg::out_item_t out_item_o
);
  import cms_pkg::*;

  site_entry_t mem [SITE_WINDOW];

  logic [SITE_AW-1:0] clr_q;
  logic [7:0]         min_q;
  in_item_t           item_q;
  site_entry_t        rdata_q;
  out_item_t          result_q;

  logic        is_cpg;
  logic        in_window;
  logic        counted;
  cnt_sel_e    sel;
  site_entry_t new_entry;
  site_entry_t shown;
  logic [CNT_N-1:0][31:0] cnt_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      min_q <= MIN_QUALITY_RESET;
    end else begin
      if (cmd_i.clr_en) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cfg_we_i) begin
        min_q <= cfg_wdata_i;
      end
    end
  end

  assign sts_o.clr_last = (clr_q == SITE_AW'(SITE_WINDOW - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      mem[clr_q] <= '0;
    end else if (cmd_i.commit && counted) begin
      mem[item_q.site_address[SITE_AW-1:0]] <= new_entry;
    end
    if (cmd_i.load) begin
      rdata_q <= mem[in_item_i.site_address[SITE_AW-1:0]];
      item_q  <= in_item_i;
    end
  end

  always_comb begin
    is_cpg = ((item_q.ref_base == ASCII_C_UP) || (item_q.ref_base == ASCII_C_LO)) &&
             ((item_q.ref_next_base == ASCII_G_UP) || (item_q.ref_next_base == ASCII_G_LO));
    in_window = 32'(item_q.site_address) < SITE_WINDOW;

    if (item_q.strand) begin
      if (item_q.read_base == ASCII_C_UP) begin
        sel = SEL_WC;
      end else if (item_q.read_base == ASCII_T_UP) begin
        sel = SEL_WT;
      end else begin
        sel = SEL_WZ;
      end
    end else if (item_q.has_next) begin
      if (item_q.read_next_base == ASCII_G_UP) begin
        sel = SEL_CC;
      end else if (item_q.read_next_base == ASCII_A_UP) begin
        sel = SEL_CT;
      end else begin
        sel = SEL_CZ;
      end
    end else begin
      sel = SEL_NONE;
    end

    counted = (item_q.action == ACT_OBSERVE) && in_window && is_cpg &&
              (item_q.quality >= min_q) && (sel != SEL_NONE);

    new_entry = rdata_q;
    if (counted) begin
      new_entry.seen = 1'b1;
      for (int j = 0; j < CNT_N; j++) begin
        // saturate at the counter maximum
        if ((3'(j) == sel) && !(&rdata_q.cnt[j])) begin
          new_entry.cnt[j] = rdata_q.cnt[j] + 1'b1;
        end
      end
    end

    shown = in_window ? new_entry : '0;
    for (int j = 0; j < CNT_N; j++) begin
      cnt_ext[j] = 32'(shown.cnt[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      result_q.is_cpg       <= is_cpg;
      result_q.counted      <= counted;
      result_q.site_seen    <= shown.seen;
      result_q.watson_c     <= cnt_ext[SEL_WC][FIELD_W-1:0];
      result_q.watson_t     <= cnt_ext[SEL_WT][FIELD_W-1:0];
      result_q.watson_other <= cnt_ext[SEL_WZ][FIELD_W-1:0];
      result_q.crick_c      <= cnt_ext[SEL_CC][FIELD_W-1:0];
      result_q.crick_t      <= cnt_ext[SEL_CT][FIELD_W-1:0];
      result_q.crick_other  <= cnt_ext[SEL_CZ][FIELD_W-1:0];
    end
  end

  assign out_item_o = result_q;

endmodule

`default_nettype wire

// ===== sv/cpg_methylation_site_counter.sv =====
// channel   direction  handshake              payload
// in        input      in_valid_i/in_stall_o   cms_pkg::in_item_t
// out       output     out_valid_o/out_stall_i cms_pkg::out_item_t
// cfg       input      cfg_we_i                cfg_wdata_i (min_quality)
//
// Each item goes through the site memory read on acceptance, then
// the read-modify-write of the site entry into the output register.
// After reset a clearing pass zeroes every site memory entry, one entry a cycle,
// during which no item is accepted.
// A stalled result holds the update cycle of the next item.
`default_nettype none

module cpg_methylation_site_counter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cms_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cms_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i
);
  import cms_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  cms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cms_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ===== sv/cms_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module cms_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input cms_pkg::out_item_t out_item_o
);
  import cms_pkg::*;

  logic no_counts;

  assign no_counts = (out_item_o.watson_c == '0) && (out_item_o.watson_t == '0) &&
                     (out_item_o.watson_other == '0) && (out_item_o.crick_c == '0) &&
                     (out_item_o.crick_t == '0) && (out_item_o.crick_other == '0);

  `CHK_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o), "stalled result changed")
  `CHK_ASSERT_NEXT(a_one_item, in_valid_i && !in_stall_o, in_stall_o, "second item taken while busy")
  `CHK_ASSERT(a_count_cpg, out_valid_o && out_item_o.counted, out_item_o.is_cpg && out_item_o.site_seen, "count without CpG record")
  `CHK_ASSERT(a_unseen_zero, out_valid_o && !out_item_o.site_seen, no_counts, "unseen site has counts")

endmodule

bind cpg_methylation_site_counter cms_checker u_cms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none

module tb;

  localparam int unsigned WATCHDOG_LIMIT = 400000;
  localparam int unsigned MAX_REPORTS    = 40;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  cms_pkg::in_item_t  in_item_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  cms_pkg::out_item_t out_item_o;
  logic               cfg_we_i    = 1'b0;
  logic [7:0]         cfg_wdata_i = '0;

  cpg_methylation_site_counter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  cms_pkg::in_item_t  base_feed_q[$];
  cms_pkg::out_item_t site_report_q[$];
  cms_pkg::cnt_vec_t  site_cnt[int unsigned];
  bit                 site_mark[int unsigned];
  logic [7:0]         min_q = cms_pkg::MIN_QUALITY_RESET;

  int unsigned        n_queued    = 0;
  int unsigned        n_accepted  = 0;
  int unsigned        n_errors    = 0;
  int unsigned        burst_left  = 1;
  int unsigned        gap_left    = 0;
  int unsigned        idle_cycles = 0;
  logic [31:0]        cyc         = '0;
  cms_pkg::out_item_t want;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic is_c(logic [7:0] b);
    return b == cms_pkg::ASCII_C_UP || b == cms_pkg::ASCII_C_LO;
  endfunction

  function automatic logic is_g(logic [7:0] b);
    return b == cms_pkg::ASCII_G_UP || b == cms_pkg::ASCII_G_LO;
  endfunction

  function automatic cms_pkg::out_item_t tally_site(cms_pkg::in_item_t it);
    cms_pkg::out_item_t r;
    cms_pkg::cnt_vec_t  cnt;
    cms_pkg::cnt_sel_e  sel;
    int unsigned        addr;
    logic               cpg;
    logic               seen;
    addr = 32'(it.site_address);
    cnt  = site_cnt.exists(addr) ? site_cnt[addr] : '0;
    seen = (site_mark.exists(addr) != 0);
    cpg  = is_c(it.ref_base) && is_g(it.ref_next_base);
    sel  = cms_pkg::SEL_NONE;
    if (it.action == cms_pkg::ACT_OBSERVE && cpg && it.quality >= min_q) begin
      if (it.strand) begin
        if (it.read_base == cms_pkg::ASCII_C_UP) sel = cms_pkg::SEL_WC;
        else if (it.read_base == cms_pkg::ASCII_T_UP) sel = cms_pkg::SEL_WT;
        else sel = cms_pkg::SEL_WZ;
      end else if (it.has_next) begin
        if (it.read_next_base == cms_pkg::ASCII_G_UP) sel = cms_pkg::SEL_CC;
        else if (it.read_next_base == cms_pkg::ASCII_A_UP) sel = cms_pkg::SEL_CT;
        else sel = cms_pkg::SEL_CZ;
      end
    end
    r = '0;
    r.is_cpg = cpg;
    if (sel != cms_pkg::SEL_NONE) begin
      if (cnt[sel] != '1) cnt[sel] = cnt[sel] + 1'b1;
      site_cnt[addr]  = cnt;
      site_mark[addr] = 1'b1;
      seen            = 1'b1;
      r.counted       = 1'b1;
    end
    r.site_seen    = seen;
    r.watson_c     = cnt[cms_pkg::SEL_WC];
    r.watson_t     = cnt[cms_pkg::SEL_WT];
    r.watson_other = cnt[cms_pkg::SEL_WZ];
    r.crick_c      = cnt[cms_pkg::SEL_CC];
    r.crick_t      = cnt[cms_pkg::SEL_CT];
    r.crick_other  = cnt[cms_pkg::SEL_CZ];
    return r;
  endfunction

  task automatic push_base(cms_pkg::action_e act, logic [15:0] addr, logic [7:0] rb,
                           logic [7:0] rnb, logic [7:0] sb, logic [7:0] snb,
                           logic hn, logic [7:0] q, logic strand);
    cms_pkg::in_item_t it;
    it.action         = act;
    it.site_address   = addr;
    it.ref_base       = rb;
    it.ref_next_base  = rnb;
    it.read_base      = sb;
    it.read_next_base = snb;
    it.has_next       = hn;
    it.quality        = q;
    it.strand         = strand;
    base_feed_q.push_back(it);
    n_queued++;
  endtask

  function automatic logic [7:0] pick_base();
    case ($urandom_range(0, 9))
      0:       return cms_pkg::ASCII_C_UP;
      1:       return cms_pkg::ASCII_T_UP;
      2:       return cms_pkg::ASCII_G_UP;
      3:       return cms_pkg::ASCII_A_UP;
      4:       return cms_pkg::ASCII_C_LO;
      5:       return cms_pkg::ASCII_G_LO;
      6:       return "t";
      7:       return "a";
      8:       return "N";
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_random(int unsigned count);
    cms_pkg::action_e act;
    logic [15:0]      addr;
    logic [7:0]       rb;
    logic [7:0]       rnb;
    logic [7:0]       q;
    repeat (count) begin
      act = ($urandom_range(0, 4) == 0) ? cms_pkg::ACT_READ : cms_pkg::ACT_OBSERVE;
      case ($urandom_range(0, 9))
        0:       addr = 16'($urandom);
        1:       addr = 16'hFFFF - 16'($urandom_range(0, 3));
        default: addr = 16'($urandom_range(0, 23));
      endcase
      if ($urandom_range(0, 6) != 0) begin
        rb  = $urandom_range(0, 1) ? cms_pkg::ASCII_C_UP : cms_pkg::ASCII_C_LO;
        rnb = $urandom_range(0, 1) ? cms_pkg::ASCII_G_UP : cms_pkg::ASCII_G_LO;
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            rb  = 8'($urandom);
            rnb = 8'($urandom);
          end
          1: begin
            rb  = cms_pkg::ASCII_C_UP;
            rnb = pick_base();
          end
          default: begin
            rb  = pick_base();
            rnb = cms_pkg::ASCII_G_LO;
          end
        endcase
      end
      case ($urandom_range(0, 5))
        0:       q = 8'($urandom);
        1:       q = min_q;
        2:       q = min_q - 8'd1;
        3:       q = 8'hFF;
        default: q = 8'(int'(min_q) + $urandom_range(0, 255 - int'(min_q)));
      endcase
      push_base(act, addr, rb, rnb, pick_base(), pick_base(), $urandom_range(0, 5) != 0, q,
                1'($urandom_range(0, 1)));
    end
  endtask

  task automatic drain();
    wait (n_accepted == n_queued && site_report_q.size() == 0);
  endtask

  task automatic write_min_quality(logic [7:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    min_q = v;
  endtask

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      if (n_errors < MAX_REPORTS)
        $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
      n_errors++;
    end
  endtask

  // Driver: bursts of random length separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        site_report_q.push_back(tally_site(in_item_i));
        n_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (base_feed_q.size() > 0) begin
          in_valid_i <= 1'b1;
          in_item_i  <= base_feed_q.pop_front();
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each item, stall on a rotating pattern.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      cyc = cyc + 1;
      if (out_valid_o === 1'b1 && !out_stall_i) begin
        if (site_report_q.size() == 0) begin
          if (n_errors < MAX_REPORTS)
            $display("%0t unexpected item: expected none actual %h", $time, out_item_o);
          n_errors++;
        end else begin
          want = site_report_q.pop_front();
          check_field("is_cpg", 16'(want.is_cpg), 16'(out_item_o.is_cpg));
          check_field("counted", 16'(want.counted), 16'(out_item_o.counted));
          check_field("site_seen", 16'(want.site_seen), 16'(out_item_o.site_seen));
          check_field("watson_c", want.watson_c, out_item_o.watson_c);
          check_field("watson_t", want.watson_t, out_item_o.watson_t);
          check_field("watson_other", want.watson_other, out_item_o.watson_other);
          check_field("crick_c", want.crick_c, out_item_o.crick_c);
          check_field("crick_t", want.crick_t, out_item_o.crick_t);
          check_field("crick_other", want.crick_other, out_item_o.crick_other);
        end
      end
      case (cyc[9:8])
        2'd0:    out_stall_i <= 1'b0;
        2'd1:    out_stall_i <= ($urandom_range(0, 3) == 0);
        2'd2:    out_stall_i <= (cyc[2:0] < 3'd3);
        default: out_stall_i <= ($urandom_range(0, 9) < 6);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o === 1'b1 && !out_stall_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_base(cms_pkg::ACT_OBSERVE, 16'd0, cms_pkg::ASCII_C_UP, cms_pkg::ASCII_G_UP,
              cms_pkg::ASCII_C_UP, cms_pkg::ASCII_A_UP, 1'b1, 8'd33, 1'b1);
    push_base(cms_pkg::ACT_OBSERVE, 16'd0, cms_pkg::ASCII_C_LO, cms_pkg::ASCII_G_LO,
              cms_pkg::ASCII_T_UP, cms_pkg::ASCII_C_UP, 1'b1, 8'd40, 1'b1);
    push_base(cms_pkg::ACT_OBSERVE, 16'd0, cms_pkg::ASCII_C_UP, cms_pkg::ASCII_G_LO,
              "N", cms_pkg::ASCII_G_UP, 1'b1, 8'd200, 1'b1);
    push_base(cms_pkg::ACT_OBSERVE, 16'd0, cms_pkg::ASCII_C_LO, cms_pkg::ASCII_G_UP,
              cms_pkg::ASCII_A_UP, cms_pkg::ASCII_G_UP, 1'b1, 8'd60, 1'b0);
    push_base(cms_pkg::ACT_OBSERVE, 16'd0, cms_pkg::ASCII_C_UP, cms_pkg::ASCII_G_UP,
              cms_pkg::ASCII_C_UP, cms_pkg::ASCII_A_UP, 1'b1, 8'd60, 1'b0);
    push_base(cms_pkg::ACT_OBSERVE, 16'd0, cms_pkg::ASCII_C_UP, cms_pkg::ASCII_G_UP,
              cms_pkg::ASCII_C_UP, cms_pkg::ASCII_G_LO, 1'b1, 8'd60, 1'b0);
    push_base(cms_pkg::ACT_OBSERVE, 16'd1, cms_pkg::ASCII_C_UP, cms_pkg::ASCII_G_UP,
              cms_pkg::ASCII_C_UP, cms_pkg::ASCII_G_UP, 1'b0, 8'd60, 1'b0);
    push_base(cms_pkg::ACT_OBSERVE, 16'd1, cms_pkg::ASCII_C_UP, cms_pkg::ASCII_G_UP,
              cms_pkg::ASCII_C_UP, cms_pkg::ASCII_G_UP, 1'b0, 8'd60, 1'b1);
    push_base(cms_pkg::ACT_OBSERVE, 16'd2, cms_pkg::ASCII_C_UP, cms_pkg::ASCII_G_UP,
              cms_pkg::ASCII_C_UP, cms_pkg::ASCII_G_UP, 1'b1, 8'd32, 1'b1);
    push_base(cms_pkg::ACT_OBSERVE, 16'd3, cms_pkg::ASCII_C_UP, cms_pkg::ASCII_A_UP,
              cms_pkg::ASCII_C_UP, cms_pkg::ASCII_G_UP, 1'b1, 8'd90, 1'b1);
    push_base(cms_pkg::ACT_OBSERVE, 16'd3, cms_pkg::ASCII_G_UP, cms_pkg::ASCII_C_UP,
              cms_pkg::ASCII_C_UP, cms_pkg::ASCII_G_UP, 1'b1, 8'd90, 1'b1);
    push_base(cms_pkg::ACT_OBSERVE, 16'd3, cms_pkg::ASCII_C_LO, cms_pkg::ASCII_C_LO,
              cms_pkg::ASCII_C_UP, cms_pkg::ASCII_G_UP, 1'b1, 8'd90, 1'b0);
    push_base(cms_pkg::ACT_READ, 16'd0, cms_pkg::ASCII_C_UP, cms_pkg::ASCII_G_UP,
              cms_pkg::ASCII_C_UP, cms_pkg::ASCII_G_UP, 1'b1, 8'd90, 1'b1);
    push_base(cms_pkg::ACT_READ, 16'd0, cms_pkg::ASCII_A_UP, cms_pkg::ASCII_T_UP,
              cms_pkg::ASCII_C_UP, cms_pkg::ASCII_G_UP, 1'b1, 8'd90, 1'b0);
    push_base(cms_pkg::ACT_READ, 16'hFFFF, cms_pkg::ASCII_C_UP, cms_pkg::ASCII_G_UP,
              cms_pkg::ASCII_C_UP, cms_pkg::ASCII_G_UP, 1'b1, 8'hFF, 1'b1);
    push_base(cms_pkg::ACT_OBSERVE, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 1'b1);
    push_base(cms_pkg::ACT_OBSERVE, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0);
    push_base(cms_pkg::ACT_OBSERVE, 16'hFFFF, cms_pkg::ASCII_C_UP, cms_pkg::ASCII_G_UP,
              cms_pkg::ASCII_T_UP, cms_pkg::ASCII_A_UP, 1'b1, 8'hFF, 1'b1);
    push_base(cms_pkg::ACT_OBSERVE, 16'hFFFF, cms_pkg::ASCII_C_UP, cms_pkg::ASCII_G_UP,
              cms_pkg::ASCII_C_LO, cms_pkg::ASCII_A_UP, 1'b1, 8'hFF, 1'b1);
    push_base(cms_pkg::ACT_OBSERVE, 16'hFFFF, cms_pkg::ASCII_C_LO, cms_pkg::ASCII_G_LO,
              cms_pkg::ASCII_T_UP, "a", 1'b1, 8'hFF, 1'b0);
    push_base(cms_pkg::ACT_READ, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0);
    push_random(250);
    drain();

    write_min_quality(8'd0);
    push_random(250);
    drain();

    write_min_quality(8'd255);
    push_random(200);
    drain();

    write_min_quality(8'($urandom_range(1, 254)));
    push_random(250);
    drain();

    write_min_quality(cms_pkg::MIN_QUALITY_RESET);
    push_random(100);
    drain();

    repeat (16) @(posedge clk_i);
    if (n_errors == 0 && site_report_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
